### hdl/gmt_pkg.sv
package gmt_pkg;

   localparam int DefaultEntries = 32;
   localparam logic [15:0] ResetOwnId = 16'd1;
   localparam logic [15:0] ResetOwnPort = 16'd0;
   localparam logic [15:0] ResetRemoveAfter = 16'd20;

   typedef enum logic [2:0] {
      ACT_TICK = 3'd0,
      ACT_JOIN_REQ = 3'd1,
      ACT_JOIN_REP = 3'd2,
      ACT_HEARTBEAT = 3'd3,
      ACT_GOSSIP = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      EV_ADDED = 3'd0,
      EV_REMOVED = 3'd1,
      EV_SEND = 3'd2,
      EV_LIST = 3'd3,
      EV_FULL = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      CSR_OWN_ID = 2'd0,
      CSR_OWN_PORT = 2'd1,
      CSR_REMOVE_AFTER = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0] action;
      logic [31:0] now;
      logic [15:0] node_id;
      logic [15:0] node_port;
      logic [31:0] heartbeat_in;
      logic [31:0] stamp_in;
   } request_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [15:0] entry_id;
      logic [15:0] entry_port;
      logic [31:0] entry_heartbeat;
      logic [31:0] entry_stamp;
      logic last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_REMOVE,
      ST_SEND,
      ST_LIST
   } state_type;

   // Signed age compared against the limit.
   function automatic logic age_ge(input logic [31:0] now, input logic [31:0] stamp,
                                   input logic [15:0] limit);
      logic [31:0] d;
      d = now - stamp;
      return !d[31] && (d >= {16'd0, limit});
   endfunction

endpackage

### hdl/gossip_membership_table.sv
// Gossip heartbeat membership table.
// Requests enter on req_* with push/full; an accepted request is queued in
// a two-entry front queue, then the back end handles one request at a time.
// Results leave on rsp_* from one output register: a result is shown while
// empty is low and is taken by pop. rsp_last marks the final result
// of one request. Configuration goes in through csr_we/csr_index/csr_wdata
// and must be written only while the block is idle.
// A request other than a tick first scans all NUM_ENTRIES slots through
// the table's single registered read port. A join request then lists the
// table, and a tick makes two walks (removals, then sends), each with one
// result per slot at most. The back end takes a new request only when the
// current one is finished; until then the front queue holds up to two.
// Reset empties the table, clears the own heartbeat and group flag and
// loads own_id 1, own_port 0, remove_after 20; no clearing pass is needed.
// While a result waits with pop low, a walk halts on its slot and resumes.
module gossip_membership_table
   import gmt_pkg::*;
#(
   parameter int NUM_ENTRIES = DefaultEntries
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [2:0] req_action,
   input  logic [31:0] req_now,
   input  logic [15:0] req_node_id,
   input  logic [15:0] req_node_port,
   input  logic [31:0] req_heartbeat_in,
   input  logic [31:0] req_stamp_in,
   output logic empty,
   input  logic pop,
   output logic [2:0] rsp_event_res,
   output logic [15:0] rsp_entry_id,
   output logic [15:0] rsp_entry_port,
   output logic [31:0] rsp_entry_heartbeat,
   output logic [31:0] rsp_entry_stamp,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] own_id_ff, own_port_ff, remove_after_ff;
   request_type req_bus, q_data;
   result_type rsp_bus;
   logic q_valid, q_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= ResetOwnId;
         own_port_ff <= ResetOwnPort;
         remove_after_ff <= ResetRemoveAfter;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID: own_id_ff <= csr_wdata;
            CSR_OWN_PORT: own_port_ff <= csr_wdata;
            CSR_REMOVE_AFTER: remove_after_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_bus = '{req_action, req_now, req_node_id, req_node_port,
                      req_heartbeat_in, req_stamp_in};

   gmt_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_in(req_bus),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   gmt_back #(.NumEntries(NUM_ENTRIES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_data(q_data), .own_id(own_id_ff), .own_port(own_port_ff),
      .remove_after(remove_after_ff), .rsp_empty(empty), .rsp_pop(pop),
      .rsp_data(rsp_bus)
   );

   assign rsp_event_res = rsp_bus.event_res;
   assign rsp_entry_id = rsp_bus.entry_id;
   assign rsp_entry_port = rsp_bus.entry_port;
   assign rsp_entry_heartbeat = rsp_bus.entry_heartbeat;
   assign rsp_entry_stamp = rsp_bus.entry_stamp;
   assign rsp_last = rsp_bus.last;

endmodule

### hdl/gmt_front.sv
module gmt_front
   import gmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  request_type req_in,
   output logic q_valid,
   input  logic q_take,
   output request_type q_data
);

   // Two-entry request queue; action codes that mean nothing are dropped here.
   request_type buf_ff [2];
   request_type buf_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic keep;
   logic do_wr;

   assign full = (cnt_ff == 2'd2);
   assign keep = (req_in.action inside {ACT_TICK, ACT_JOIN_REQ, ACT_JOIN_REP,
                                        ACT_HEARTBEAT, ACT_GOSSIP});
   assign do_wr = push && !full && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = buf_ff[rd_ptr_ff];

   always_comb begin
      buf_in = buf_ff;
      if (do_wr) begin
         buf_in[wr_ptr_ff] = req_in;
      end
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + {1'b0, do_wr} - {1'b0, q_take && q_valid};
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("full queue with pointers apart");

endmodule

### hdl/gmt_back.sv
module gmt_back
   import gmt_pkg::*;
#(
   parameter int NumEntries = DefaultEntries
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_take,
   input  request_type q_data,
   input  logic [15:0] own_id,
   input  logic [15:0] own_port,
   input  logic [15:0] remove_after,
   output logic rsp_empty,
   input  logic rsp_pop,
   output result_type rsp_data
);

   localparam int IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
   localparam int CntW = $clog2(NumEntries + 1);
   localparam logic [CntW-1:0] LastIdx = CntW'(NumEntries - 1);

   logic [15:0] mem_id [NumEntries];
   logic [15:0] mem_port [NumEntries];
   logic [31:0] mem_hb [NumEntries];
   logic [31:0] mem_st [NumEntries];
   logic [NumEntries-1:0] valid_ff, valid_in;

   state_type state_ff, state_in;
   request_type req_ff, req_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic [31:0] hit_hb_ff, hit_hb_in;
   logic free_ff, free_in;
   logic [IdxW-1:0] fidx_ff, fidx_in;
   logic [31:0] own_hb_ff, own_hb_in;
   logic in_group_ff, in_group_in;
   logic out_v_ff, out_v_in;
   result_type out_ff, out_in;

   // Read port, registered.
   logic [IdxW-1:0] rd_addr;
   logic rd_hold;
   logic [15:0] rd_id_ff, rd_port_ff;
   logic [31:0] rd_hb_ff, rd_st_ff;
   logic rd_valid_ff;
   logic [CntW-1:0] rd_idx_ff;

   logic wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [15:0] wr_id, wr_port;
   logic [31:0] wr_hb, wr_st;

   logic out_free;
   logic more_valid;
   logic [NumEntries-1:0] above_mask;
   logic is_self, fresh;

   assign rd_addr = idx_ff[IdxW-1:0];
   assign out_free = !out_v_ff || rsp_pop;
   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;

   // A stalled walk keeps the slot it is showing in the read register.
   assign rd_hold = (state_ff == ST_REMOVE || state_ff == ST_SEND || state_ff == ST_LIST) &&
                    (idx_ff != '0) && !out_free;

   always_ff @(posedge clock) begin
      if (!rd_hold) begin
         rd_id_ff <= mem_id[rd_addr];
         rd_port_ff <= mem_port[rd_addr];
         rd_hb_ff <= mem_hb[rd_addr];
         rd_st_ff <= mem_st[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_idx_ff <= idx_ff;
      end
      if (wr_en) begin
         mem_id[wr_addr] <= wr_id;
         mem_port[wr_addr] <= wr_port;
         mem_hb[wr_addr] <= wr_hb;
         mem_st[wr_addr] <= wr_st;
      end
   end

   // Whether any valid slot sits above the one read (for the last flag).
   always_comb begin
      for (int i = 0; i < NumEntries; i++) begin
         above_mask[i] = (CntW'(i) > rd_idx_ff);
      end
   end
   assign more_valid = |(valid_ff & above_mask);

   assign is_self = (req_ff.node_id == own_id) && (req_ff.node_port == own_port);
   assign fresh = !age_ge(req_ff.now, req_ff.stamp_in, remove_after);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      hit_hb_in = hit_hb_ff;
      free_in = free_ff;
      fidx_in = fidx_ff;
      own_hb_in = own_hb_ff;
      in_group_in = in_group_ff;
      valid_in = valid_ff;
      out_v_in = out_v_ff && !rsp_pop;
      out_in = out_ff;
      q_take = 1'b0;
      wr_en = 1'b0;
      wr_addr = hit_ff;
      wr_id = req_ff.node_id;
      wr_port = req_ff.node_port;
      wr_hb = 32'd1;
      wr_st = req_ff.now;
      case (state_ff)
         ST_IDLE: begin
            q_take = q_valid;
            if (q_valid) begin
               req_in = q_data;
               idx_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
               if (q_data.action == ACT_TICK) begin
                  if (in_group_ff || (own_id == ResetOwnId && own_port == ResetOwnPort)) begin
                     own_hb_in = own_hb_ff + 32'd1;
                     state_in = ST_REMOVE;
                  end
               end else begin
                  if (q_data.action == ACT_JOIN_REP) begin
                     in_group_in = 1'b1;
                  end
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // One slot a cycle through the registered read port.
            if (idx_ff != CntW'(NumEntries)) begin
               idx_in = idx_ff + 1'b1;
            end
            if (idx_ff != '0) begin
               if (rd_valid_ff && !found_ff && rd_id_ff == req_ff.node_id &&
                   rd_port_ff == req_ff.node_port) begin
                  found_in = 1'b1;
                  hit_in = rd_idx_ff[IdxW-1:0];
                  hit_hb_in = rd_hb_ff;
               end
               if (!rd_valid_ff && !free_ff) begin
                  free_in = 1'b1;
                  fidx_in = rd_idx_ff[IdxW-1:0];
               end
               if (rd_idx_ff == LastIdx) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (found_ff) begin
                  if (req_ff.action == ACT_HEARTBEAT) begin
                     wr_en = 1'b1;
                     wr_hb = hit_hb_ff + 32'd1;
                  end else if (req_ff.action == ACT_GOSSIP &&
                               req_ff.heartbeat_in > hit_hb_ff) begin
                     wr_en = 1'b1;
                     wr_hb = req_ff.heartbeat_in;
                  end
               end else if (req_ff.action != ACT_GOSSIP || (!is_self && fresh)) begin
                  wr_hb = (req_ff.action == ACT_GOSSIP) ? req_ff.heartbeat_in : 32'd1;
                  out_v_in = 1'b1;
                  out_in.entry_id = req_ff.node_id;
                  out_in.entry_port = req_ff.node_port;
                  out_in.entry_heartbeat = wr_hb;
                  out_in.entry_stamp = req_ff.now;
                  out_in.last = 1'b1;
                  if (free_ff) begin
                     wr_en = 1'b1;
                     wr_addr = fidx_ff;
                     valid_in[fidx_ff] = 1'b1;
                     out_in.event_res = EV_ADDED;
                  end else begin
                     out_in.event_res = EV_FULL;
                  end
               end
               if (req_ff.action == ACT_JOIN_REQ) begin
                  if (out_v_in && |valid_in) begin
                     out_in.last = 1'b0;
                  end
                  idx_in = '0;
                  state_in = ST_LIST;
               end
            end
            if (found_ff && req_ff.action == ACT_HEARTBEAT && !out_free) begin
               wr_en = 1'b0;
            end
         end
         ST_REMOVE, ST_SEND, ST_LIST: begin
            // idx_ff leads the registered read by one; it holds while stalled.
            if (idx_ff == '0) begin
               idx_in = CntW'(1);
               if (state_ff == ST_LIST && valid_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               if (idx_ff != CntW'(NumEntries)) begin
                  idx_in = idx_ff + 1'b1;
               end
               if (rd_valid_ff && valid_ff[rd_idx_ff[IdxW-1:0]]) begin
                  out_in.entry_id = rd_id_ff;
                  out_in.entry_port = rd_port_ff;
                  out_in.entry_stamp = rd_st_ff;
                  out_in.entry_heartbeat = rd_hb_ff;
                  out_in.last = 1'b0;
                  if (state_ff == ST_REMOVE) begin
                     if (age_ge(req_ff.now, rd_st_ff, remove_after)) begin
                        valid_in[rd_idx_ff[IdxW-1:0]] = 1'b0;
                        out_v_in = 1'b1;
                        out_in.event_res = EV_REMOVED;
                        out_in.last = !more_valid && !(|(valid_ff & ~above_mask &
                           ~(NumEntries'(1) << rd_idx_ff[IdxW-1:0])));
                     end
                  end else begin
                     out_v_in = 1'b1;
                     out_in.event_res = (state_ff == ST_SEND) ? EV_SEND : EV_LIST;
                     if (state_ff == ST_SEND) begin
                        out_in.entry_heartbeat = own_hb_ff;
                     end
                     out_in.last = !more_valid;
                  end
               end
               if (rd_idx_ff == LastIdx) begin
                  idx_in = '0;
                  state_in = (state_ff == ST_REMOVE) ? ST_SEND : ST_IDLE;
               end
            end
            // Under a stalled output the walk and the read register both hold.
            if (idx_ff != '0 && !out_free) begin
               idx_in = idx_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      hit_ff <= hit_in;
      hit_hb_ff <= hit_hb_in;
      fidx_ff <= fidx_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
         own_hb_ff <= '0;
         in_group_ff <= 1'b0;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         free_ff <= free_in;
         own_hb_ff <= own_hb_in;
         in_group_ff <= in_group_in;
         valid_ff <= valid_in;
         out_v_ff <= out_v_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_pop) |=> (out_v_ff && $stable(out_ff)))
      else $error("result changed while waiting");
   assert property (@(posedge clock) disable iff (reset)
      q_take |-> (state_ff == ST_IDLE))
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && found_ff) |-> !(state_in == ST_IDLE && valid_in != valid_ff))
      else $error("known peer changed the slot map");

endmodule
